// ===== rtl/wbps_pkg.sv =====
// Types and fixed constants for the wildcard byte pattern scan core.
// No dependencies; imported by every module of the block.
`default_nettype none

package wbps_pkg;

  localparam int BYTE_W     = 8;
  localparam int PIDX_W     = 7;
  localparam int LEN_W      = 8;
  localparam int RES_OFF_W  = 32;
  localparam int GROUP_W    = 16;
  localparam int FIFO_DEPTH = 8;
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic              wild;
    logic [BYTE_W-1:0] value;
  } pat_entry_t;

  typedef struct packed {
    logic       shift;
    logic       rotate;
    logic       load;
    pat_entry_t load_entry;
  } cell_ctl_t;

  typedef struct packed {
    logic                 last;
    logic                 enough;
    logic [RES_OFF_W-1:0] offset;
  } meta_t;

  typedef struct packed {
    logic                 found;
    logic [RES_OFF_W-1:0] offset;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/wbps_cell.sv =====
// One compare cell: a window byte, a pattern entry and a registered match bit.
// Bytes pass up the chain on each scan, entries on each rotation step.
// Depends on wbps_pkg.
`default_nettype none

module wbps_cell
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = 128,
  parameter int IDX         = 0
) (
  input  wire logic                               clk,
  input  wire cell_ctl_t                          ctl,
  input  wire logic [$clog2(MAX_PATTERN)-1:0]     load_cell,
  input  wire logic [$clog2(MAX_PATTERN+1)-1:0]   alen,
  input  wire logic [BYTE_W-1:0]                  byte_in,
  input  wire pat_entry_t                         pat_in,
  output logic [BYTE_W-1:0]                       byte_out,
  output pat_entry_t                              pat_out,
  output logic                                    ok_out
);

  localparam int IW = $clog2(MAX_PATTERN);
  localparam int LW = $clog2(MAX_PATTERN + 1);

  logic [BYTE_W-1:0] byte_r;
  pat_entry_t        pat_r;
  logic              ok_r;
  logic              active;
  logic              ok_nxt;

  always_comb begin
    active = LW'(IDX) < alen;
    ok_nxt = !active || pat_r.wild || (byte_r == pat_r.value);
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= byte_in;
    end
    if (ctl.rotate) begin
      pat_r <= pat_in;
    end else if (ctl.load && (load_cell == IW'(IDX))) begin
      pat_r <= ctl.load_entry;
    end
    ok_r <= ok_nxt;
  end

  assign byte_out = byte_r;
  assign pat_out  = pat_r;
  assign ok_out   = ok_r;

endmodule

`default_nettype wire

// ===== rtl/wbps_out_fifo.sv =====
// Small result queue between the compare pipeline and the output channel.
// Depends on wbps_pkg.
`default_nettype none

module wbps_out_fifo
  import wbps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire result_t     wr_data,
  input  wire logic        rd_ready,
  output logic             rd_valid,
  output result_t          rd_data,
  output logic [FCNT_W-1:0] count
);

  localparam int PW = $clog2(FIFO_DEPTH);

  result_t           mem [FIFO_DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [FCNT_W-1:0] cnt_r;
  logic              pop;

  assign rd_valid = cnt_r != '0;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr_r];
  assign count    = cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({wr_en, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wildcard_byte_pattern_scan_core.sv =====
// Wildcard byte pattern scan core: top level.
// Depends on wbps_pkg, wbps_cell and wbps_out_fifo.
//
// Usage:
//  - in_*: one transfer per item. in_mode 0 loads pattern entry in_pattern_index
//    (value and wildcard mark); in_mode 1 feeds one region byte, in_last_byte
//    closing the region.
//  - out_*: at most one result per scanned byte: out_found with the offset of
//    the first matching byte, or a miss on the closing byte if no match came.
//  - cfg_*: writes pattern_length; accepted every cycle.
// Throughput is one item per cycle while in_ready is high. A scanned byte
// passes the window byte, cell compare and group AND registers; the final
// decision then writes its result to the output queue, presented from the following cycle.
// Pattern entries sit in the cells rotated by pattern_length - 1. After a
// length write the store rotates one cell per cycle until it reaches the new
// position, with in_ready low meanwhile.
// An eight-entry result queue decouples the output: when the receiver stalls,
// input stays open while queue plus in-flight bytes leave room, then in_ready
// drops. Reset sets pattern_length to 1 and clears offset, fill and match
// state; the pattern store is undefined until loaded.
`default_nettype none

module wildcard_byte_pattern_scan_core
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = 128,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_mode,
  input  wire logic [PIDX_W-1:0]    in_pattern_index,
  input  wire logic [BYTE_W-1:0]    in_pattern_value,
  input  wire logic                 in_pattern_wild,
  input  wire logic [BYTE_W-1:0]    in_data_byte,
  input  wire logic                 in_last_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_found,
  output logic [RES_OFF_W-1:0]      out_match_offset,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [LEN_W-1:0]     cfg_pattern_length
);

  localparam int IW   = $clog2(MAX_PATTERN);
  localparam int LW   = $clog2(MAX_PATTERN + 1);
  localparam int NG   = (MAX_PATTERN + GROUP_W - 1) / GROUP_W;
  localparam int CMPW = (LW > LEN_W) ? LW : LEN_W;
  localparam int XW   = (((IW + 1) > PIDX_W) ? (IW + 1) : PIDX_W) + 1;

  logic [LEN_W-1:0]       len_r;
  logic [IW-1:0]          base_r;
  logic [OFFSET_BITS-1:0] cnt_r;
  logic [LW-1:0]          fill_r;
  logic                   rep_r;
  logic                   v0_r, v1_r, v2_r;
  meta_t                  m0_r, m1_r, m2_r;
  logic [NG-1:0]          grp_r;

  logic [CMPW-1:0]        len_ext;
  logic [LW-1:0]          alen;
  logic [IW-1:0]          tgt;
  logic                   rot;
  logic                   in_fire, scan_fire, load_fire, idx_ok;
  logic [IW:0]            base_w, idx_w;
  logic [IW-1:0]          load_cell;
  logic [OFFSET_BITS-1:0] cnt_inc, off_full;
  logic [LW-1:0]          fill_inc;
  logic                   enough;
  logic [FCNT_W:0]        busy;
  logic [FCNT_W-1:0]      fcnt;
  cell_ctl_t              ctl;
  logic                   all_ok, hit, emit;
  result_t                res, out_res;

  logic [BYTE_W-1:0]      byte_q [MAX_PATTERN];
  pat_entry_t             pat_q  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] ok_vec;
  logic [NG*GROUP_W-1:0]  ok_pad;

  // active length and rotation target
  always_comb begin
    len_ext = CMPW'(len_r);
    if (len_ext > CMPW'(MAX_PATTERN)) begin
      alen = LW'(MAX_PATTERN);
    end else begin
      alen = LW'(len_ext);
    end
    tgt = (alen == '0) ? IW'(MAX_PATTERN - 1) : IW'(alen - 1'b1);
    rot = base_r != tgt;
  end

  assign busy = (FCNT_W+1)'(fcnt) + (FCNT_W+1)'(v0_r) + (FCNT_W+1)'(v1_r)
              + (FCNT_W+1)'(v2_r);
  assign in_ready  = !rot && (busy < (FCNT_W+1)'(FIFO_DEPTH));
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign scan_fire = in_fire && in_mode;
  assign load_fire = in_fire && !in_mode;

  // load target cell: (base - index) mod MAX_PATTERN
  always_comb begin
    idx_ok = XW'(in_pattern_index) < XW'(MAX_PATTERN);
    base_w = {1'b0, base_r};
    idx_w  = (IW+1)'(in_pattern_index);
    if (base_w >= idx_w) begin
      load_cell = IW'(base_w - idx_w);
    end else begin
      load_cell = IW'(base_w + (IW+1)'(MAX_PATTERN) - idx_w);
    end
  end

  always_comb begin
    ctl.shift            = scan_fire;
    ctl.rotate           = rot;
    ctl.load             = load_fire && idx_ok;
    ctl.load_entry.wild  = in_pattern_wild;
    ctl.load_entry.value = in_pattern_value;
  end

  // front end: offset and fill
  always_comb begin
    cnt_inc  = cnt_r + 1'b1;
    off_full = cnt_inc - OFFSET_BITS'(alen);
    fill_inc = (fill_r == LW'(MAX_PATTERN)) ? fill_r : fill_r + 1'b1;
    enough   = (alen != '0) && (fill_inc >= alen);
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
      wbps_cell #(
        .MAX_PATTERN (MAX_PATTERN),
        .IDX         (gi)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .load_cell (load_cell),
        .alen      (alen),
        .byte_in   ((gi == 0) ? in_data_byte : byte_q[(gi + MAX_PATTERN - 1) % MAX_PATTERN]),
        .pat_in    (pat_q[(gi + MAX_PATTERN - 1) % MAX_PATTERN]),
        .byte_out  (byte_q[gi]),
        .pat_out   (pat_q[gi]),
        .ok_out    (ok_vec[gi])
      );
    end
  endgenerate

  always_comb begin
    ok_pad                  = '1;
    ok_pad[MAX_PATTERN-1:0] = ok_vec;
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      grp_r[g] <= &ok_pad[g*GROUP_W +: GROUP_W];
    end
  end

  // final decision
  always_comb begin
    all_ok     = &grp_r;
    hit        = v2_r && m2_r.enough && all_ok && !rep_r;
    emit       = v2_r && !rep_r && (hit || m2_r.last);
    res.found  = hit;
    res.offset = hit ? m2_r.offset : '0;
  end

  always_ff @(posedge clk) begin
    if (scan_fire) begin
      m0_r.last   <= in_last_byte;
      m0_r.enough <= enough;
      m0_r.offset <= RES_OFF_W'(off_full);
    end
    m1_r <= m0_r;
    m2_r <= m1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= LEN_W'(1);
      base_r <= '0;
      cnt_r  <= '0;
      fill_r <= '0;
      rep_r  <= 1'b0;
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        len_r <= cfg_pattern_length;
      end
      if (rot) begin
        base_r <= (base_r == IW'(MAX_PATTERN - 1)) ? '0 : base_r + 1'b1;
      end
      if (scan_fire) begin
        cnt_r  <= in_last_byte ? '0 : cnt_inc;
        fill_r <= in_last_byte ? '0 : fill_inc;
      end
      if (v2_r) begin
        rep_r <= m2_r.last ? 1'b0 : (rep_r || hit);
      end
      v0_r <= scan_fire;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  wbps_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (emit),
    .wr_data  (res),
    .rd_ready (out_ready),
    .rd_valid (out_valid),
    .rd_data  (out_res),
    .count    (fcnt)
  );

  assign out_found        = out_res.found;
  assign out_match_offset = out_res.offset;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (fcnt < FCNT_W'(FIFO_DEPTH)) || (out_valid && out_ready))
    else $error("result queue overflow");

  a_hit_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (hit && !m2_r.last) |=> rep_r)
    else $error("match not recorded");

  a_region_end: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_fire && in_last_byte) |=> (cnt_r == '0) && (fill_r == '0))
    else $error("region state not cleared");

  a_no_scan_rotating: assert property (@(posedge clk) disable iff (!rst_n)
    rot |=> !v0_r)
    else $error("byte taken during rotation");

endmodule

`default_nettype wire
